### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent property, clocked and reset-qualified
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// implication on the same clock and reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication on the same clock and reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/dwpw_pkg.sv
// package of the window pixel writer: constants, register indexes and item type
package dwpw_pkg;

  localparam int unsigned COORD_BITS_DEF = 9;
  localparam int unsigned WordBits       = 16;

  localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  localparam logic [1:0] REG_X_START = 2'd0;
  localparam logic [1:0] REG_X_END   = 2'd1;
  localparam logic [1:0] REG_Y_START = 2'd2;
  localparam logic [1:0] REG_Y_END   = 2'd3;

  localparam logic [15:0] X_END_RST = 16'd239;
  localparam logic [15:0] Y_END_RST = 16'd319;

  // position of a word within the writes of one pixel
  localparam logic [2:0] WORD_COL_CMD = 3'd0;
  localparam logic [2:0] WORD_COL_HI  = 3'd1;
  localparam logic [2:0] WORD_COL_LO  = 3'd2;
  localparam logic [2:0] WORD_ROW_CMD = 3'd3;
  localparam logic [2:0] WORD_ROW_HI  = 3'd4;
  localparam logic [2:0] WORD_ROW_LO  = 3'd5;
  localparam logic [2:0] WORD_MEM_CMD = 3'd6;
  localparam logic [2:0] WORD_PIXEL   = 3'd7;

  typedef struct packed {
    logic                header;
    logic                done;
    logic [WordBits-1:0] col_start;
    logic [WordBits-1:0] row;
    logic [WordBits-1:0] pixel;
  } item_t;

endpackage

### rtl/dwpw_pos.sv
// window position tracking: row header decision, done flag and offset update
module dwpw_pos #(
  parameter int unsigned COORD_BITS = dwpw_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic [15:0]           pixel_color_i,
  input  logic                  accept_i,
  output dwpw_pkg::item_t       item_o
);
  import dwpw_pkg::*;

  localparam int unsigned SumBits = COORD_BITS + 1;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS-1:0] xe, ye, x, y;
  logic [SumBits-1:0]    x_sum, y_sum;
  logic                  row_end, win_end;

  always_comb begin
    xe      = (x_end_i < x_start_i) ? x_start_i : x_end_i;
    ye      = (y_end_i < y_start_i) ? y_start_i : y_end_i;
    x_sum   = SumBits'(x_start_i) + SumBits'(col_q);
    y_sum   = SumBits'(y_start_i) + SumBits'(row_q);
    // clamp when the window shrank under a stored offset
    x       = (x_sum > SumBits'(xe)) ? xe : x_sum[COORD_BITS-1:0];
    y       = (y_sum > SumBits'(ye)) ? ye : y_sum[COORD_BITS-1:0];
    row_end = (x == xe);
    win_end = row_end && (y == ye);

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (win_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = (y - y_start_i) + COORD_BITS'(1);
      end else begin
        col_d = (x - x_start_i) + COORD_BITS'(1);
      end
    end

    item_o.header    = (col_q == '0);
    item_o.done      = win_end;
    item_o.col_start = WordBits'(x_start_i);
    item_o.row       = WordBits'(y);
    item_o.pixel     = pixel_color_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/dwpw_seq.sv
// item register and word sequencer feeding the registered bus output
module dwpw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dwpw_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            is_command_o,
  output logic [15:0]     bus_word_o,
  output logic            item_last_o,
  output logic            window_done_o
);
  import dwpw_pkg::*;

  item_t       it_q;
  logic        it_valid_q, it_valid_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic        cmd_q, last_q, done_q;
  logic [15:0] word_q;
  logic        cmd_n;
  logic [15:0] word_n;
  logic        out_free, emit, it_done, load;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    emit       = it_valid_q && out_free;
    it_done    = emit && (idx_q == WORD_PIXEL);
    in_ready_o = !it_valid_q || it_done;
    load       = in_valid_i && in_ready_o;

    if (load) begin
      idx_d = item_i.header ? WORD_COL_CMD : WORD_PIXEL;
    end else if (emit) begin
      idx_d = idx_q + 3'd1;
    end else begin
      idx_d = idx_q;
    end

    if (load) begin
      it_valid_d = 1'b1;
    end else if (it_done) begin
      it_valid_d = 1'b0;
    end else begin
      it_valid_d = it_valid_q;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    cmd_n  = 1'b0;
    word_n = it_q.pixel;
    case (idx_q)
      WORD_COL_CMD: begin
        cmd_n  = 1'b1;
        word_n = {8'h00, CMD_COL_ADDR};
      end
      WORD_COL_HI:  word_n = {8'h00, it_q.col_start[15:8]};
      WORD_COL_LO:  word_n = {8'h00, it_q.col_start[7:0]};
      WORD_ROW_CMD: begin
        cmd_n  = 1'b1;
        word_n = {8'h00, CMD_ROW_ADDR};
      end
      WORD_ROW_HI:  word_n = {8'h00, it_q.row[15:8]};
      WORD_ROW_LO:  word_n = {8'h00, it_q.row[7:0]};
      WORD_MEM_CMD: begin
        cmd_n  = 1'b1;
        word_n = {8'h00, CMD_MEM_WRITE};
      end
      WORD_PIXEL:   word_n = it_q.pixel;
      default:      word_n = it_q.pixel;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_valid_q  <= 1'b0;
      idx_q       <= WORD_COL_CMD;
      out_valid_q <= 1'b0;
    end else begin
      it_valid_q  <= it_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      it_q <= item_i;
    end
    if (emit) begin
      cmd_q  <= cmd_n;
      word_q <= word_n;
      last_q <= (idx_q == WORD_PIXEL);
      done_q <= it_q.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_command_o  = cmd_q;
  assign bus_word_o    = word_q;
  assign item_last_o   = last_q;
  assign window_done_o = done_q;

endmodule

### rtl/display_window_pixel_writer.sv
// Window pixel writer top level: config registers, position tracking and word sequencer.
// A pixel inside a row costs one output transfer, so a row streams at one pixel per cycle
// while the bus does not stall; the first pixel of each row costs eight transfers (seven
// address/command words and the pixel) and holds the input meanwhile. The pace is set by
// the single bus output register, fed from a one-item holding register that an accepted
// pixel enters first. The user must write corner registers through the plain write port
// only while no pixel is in flight; the block does not enforce it. An end below its start
// acts as the start; after the window's last pixel the position wraps to the top-left.
module display_window_pixel_writer #(
  parameter int unsigned COORD_BITS = dwpw_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           pixel_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_command_o,
  output logic [15:0]           bus_word_o,
  output logic                  item_last_o,
  output logic                  window_done_o
);
  import dwpw_pkg::*;

  logic [COORD_BITS-1:0] x_start_q, x_end_q, y_start_q, y_end_q;
  item_t                 item;
  logic                  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= '0;
      x_end_q   <= COORD_BITS'(X_END_RST);
      y_start_q <= '0;
      y_end_q   <= COORD_BITS'(Y_END_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_START: x_start_q <= cfg_data_i;
        REG_X_END:   x_end_q   <= cfg_data_i;
        REG_Y_START: y_start_q <= cfg_data_i;
        REG_Y_END:   y_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  dwpw_pos #(
    .COORD_BITS(COORD_BITS)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .x_start_i    (x_start_q),
    .x_end_i      (x_end_q),
    .y_start_i    (y_start_q),
    .y_end_i      (y_end_q),
    .pixel_color_i(pixel_color_i),
    .accept_i     (accept),
    .item_o       (item)
  );

  dwpw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_command_o (is_command_o),
    .bus_word_o   (bus_word_o),
    .item_last_o  (item_last_o),
    .window_done_o(window_done_o)
  );

endmodule

### rtl/dwpw_checker.sv
// port-level checks of the window pixel writer and their bind
`include "assert_macros.svh"

module dwpw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_command_o,
  input logic [15:0] bus_word_o,
  input logic        item_last_o,
  input logic        window_done_o
);
  import dwpw_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o && out_ready_i;

  // stalled output word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(bus_word_o) && $stable(is_command_o) && $stable(item_last_o) && $stable(window_done_o))

  // a command never closes a pixel
  `ASSERT_IMPL(a_cmd_not_last, clk_i, rst_ni, out_valid_o && is_command_o, !item_last_o)

  // command words carry only a byte
  `ASSERT_IMPL(a_cmd_byte, clk_i, rst_ni, out_valid_o && is_command_o, bus_word_o[15:8] == 8'h00)

  // memory write command is followed at once by the pixel
  `ASSERT_NEXT(a_mem_then_pixel, clk_i, rst_ni, out_xfer && is_command_o && bus_word_o == {8'h00, CMD_MEM_WRITE}, out_valid_o && !is_command_o && item_last_o && $stable(window_done_o))

endmodule

bind display_window_pixel_writer dwpw_checker u_dwpw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .is_command_o (is_command_o),
  .bus_word_o   (bus_word_o),
  .item_last_o  (item_last_o),
  .window_done_o(window_done_o)
);

### verif/display_window_pixel_writer_test.sv
// self-checking testbench of the window pixel writer: directed table, then random windows
module display_window_pixel_writer_test;
  import dwpw_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] word;
    logic        last;
    logic        done;
  } bus_write_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [15:0] value;
    logic        typed;
    logic        hdr;
    logic        done;
    logic [CB-1:0] col;
    logic [CB-1:0] row;
  } stim_row_t;

  localparam int NUM_DIRECTED = 29;

  // typed rows carry the writes they must cause; the rest go through the predictor
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{ROW_PIXEL, REG_X_START, 16'h0000, 1'b1, 1'b1, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'hFFFF, 1'b1, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_X_START, 16'd510,  1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_X_END,   16'd511,  1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_Y_START, 16'd510,  1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_Y_END,   16'd511,  1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h8001, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h7FFE, 1'b1, 1'b1, 1'b0, 9'd510, 9'd511},
    '{ROW_PIXEL, REG_X_START, 16'hAAAA, 1'b1, 1'b0, 1'b1, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h5555, 1'b1, 1'b1, 1'b0, 9'd510, 9'd510},
    '{ROW_REG,   REG_X_END,   16'd0,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_Y_END,   16'd0,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h1234, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h4321, 1'b1, 1'b1, 1'b1, 9'd510, 9'd510},
    '{ROW_REG,   REG_X_START, 16'd0,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_Y_START, 16'd0,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h00FF, 1'b1, 1'b1, 1'b1, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'hFF00, 1'b1, 1'b1, 1'b1, 9'd0,   9'd0},
    '{ROW_REG,   REG_X_END,   16'd3,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_Y_END,   16'd1,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h0001, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h0002, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h0004, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h0008, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h1000, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_REG,   REG_X_START, 16'd2,    1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h2000, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'h4000, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0},
    '{ROW_PIXEL, REG_X_START, 16'hC3A5, 1'b0, 1'b0, 1'b0, 9'd0,   9'd0}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = REG_X_START;
  logic [CB-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [15:0]   pixel_color_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b1;
  logic          is_command_o;
  logic [15:0]   bus_word_o;
  logic          item_last_o;
  logic          window_done_o;

  display_window_pixel_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_color_i (pixel_color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_command_o  (is_command_o),
    .bus_word_o    (bus_word_o),
    .item_last_o   (item_last_o),
    .window_done_o (window_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // window corners and position as the block should hold them
  logic [CB-1:0] win_x_start = '0;
  logic [CB-1:0] win_x_end   = CB'(X_END_RST);
  logic [CB-1:0] win_y_start = '0;
  logic [CB-1:0] win_y_end   = CB'(Y_END_RST);
  logic [CB-1:0] col_pos = '0;
  logic [CB-1:0] row_pos = '0;

  bus_write_t  expected_writes [$];
  int unsigned mismatch_count = 0;
  int unsigned src_gap_max = 7;
  int unsigned sink_stall_max = 7;
  int unsigned stall_left = 0;

  function automatic void queue_pixel_writes(bit hdr, bit done, logic [CB-1:0] col,
                                             logic [CB-1:0] row, logic [15:0] pix);
    if (hdr) begin
      expected_writes.push_back('{1'b1, {8'h00, CMD_COL_ADDR}, 1'b0, done});
      expected_writes.push_back('{1'b0, {8'h00, 8'(col >> 8)}, 1'b0, done});
      expected_writes.push_back('{1'b0, {8'h00, col[7:0]}, 1'b0, done});
      expected_writes.push_back('{1'b1, {8'h00, CMD_ROW_ADDR}, 1'b0, done});
      expected_writes.push_back('{1'b0, {8'h00, 8'(row >> 8)}, 1'b0, done});
      expected_writes.push_back('{1'b0, {8'h00, row[7:0]}, 1'b0, done});
      expected_writes.push_back('{1'b1, {8'h00, CMD_MEM_WRITE}, 1'b0, done});
    end
    expected_writes.push_back('{1'b0, pix, 1'b1, done});
  endfunction

  // position of the pixel just taken, then step to the next one
  function automatic void advance_window(output bit hdr, output bit done,
                                         output logic [CB-1:0] row);
    logic [CB-1:0] xe;
    logic [CB-1:0] ye;
    logic [CB:0]   x;
    logic [CB:0]   y;
    bit            row_end;
    xe = (win_x_end < win_x_start) ? win_x_start : win_x_end;
    ye = (win_y_end < win_y_start) ? win_y_start : win_y_end;
    x = (CB+1)'(win_x_start) + (CB+1)'(col_pos);
    y = (CB+1)'(win_y_start) + (CB+1)'(row_pos);
    if (x > (CB+1)'(xe)) x = (CB+1)'(xe);
    if (y > (CB+1)'(ye)) y = (CB+1)'(ye);
    row_end = (x[CB-1:0] == xe);
    done = row_end && (y[CB-1:0] == ye);
    hdr = (col_pos == '0);
    row = y[CB-1:0];
    if (done) begin
      col_pos = '0;
      row_pos = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = y[CB-1:0] - win_y_start + CB'(1);
    end else begin
      col_pos = x[CB-1:0] - win_x_start + CB'(1);
    end
  endfunction

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CB-1:0] val);
    drain_writes();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_X_START: win_x_start = val;
      REG_X_END:   win_x_end = val;
      REG_Y_START: win_y_start = val;
      REG_Y_END:   win_y_end = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [15:0] pix, input bit typed, input bit t_hdr,
                            input bit t_done, input logic [CB-1:0] t_col,
                            input logic [CB-1:0] t_row);
    int unsigned   gap;
    bit            hdr;
    bit            done;
    logic [CB-1:0] row;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_window(hdr, done, row);
    if (typed) queue_pixel_writes(t_hdr, t_done, t_col, t_row, pix);
    else queue_pixel_writes(hdr, done, win_x_start, row, pix);
  endtask

  task automatic pick_span(output logic [CB-1:0] lo, output logic [CB-1:0] hi);
    int unsigned ext;
    lo = CB'($urandom_range(0, 511));
    ext = $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = '1;
        hi = '1;
      end
      2: hi = CB'($urandom_range(0, 511));
      default: hi = (lo + ext > 511) ? '1 : CB'(lo + ext);
    endcase
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // bus side: check each transfer, then stall for a random while
  always @(posedge clk_i) begin
    bus_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write expected none got cmd=%b word=%h last=%b done=%b",
                 $time, is_command_o, bus_word_o, item_last_o, window_done_o);
        mismatch_count++;
      end else begin
        want = expected_writes.pop_front();
        check_field("is_command", want.cmd, is_command_o);
        check_field("bus_word", want.word, bus_word_o);
        check_field("item_last", want.last, item_last_o);
        check_field("window_done", want.done, window_done_o);
      end
      stall_left = $urandom_range(0, sink_stall_max);
      if (stall_left != 0) out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_ready_i <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [CB-1:0] xs;
    logic [CB-1:0] xe;
    logic [CB-1:0] ys;
    logic [CB-1:0] ye;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_REG) begin
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value[CB-1:0]);
      end else begin
        send_pixel(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].hdr,
                   DIRECTED_ROWS[i].done, DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].row);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      pick_span(xs, xe);
      pick_span(ys, ye);
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_X_START, xs);
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_X_END, xe);
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_Y_START, ys);
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_Y_END, ye);
      src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      for (int k = 0; k < 24; k++) begin
        // let the bus side empty out in the middle of a window
        if (ph == 3 && k == 12) drain_writes();
        send_pixel(16'($urandom_range(0, 65535)), 1'b0, 1'b0, 1'b0, '0, '0);
      end
    end

    drain_writes();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dwpw_pkg.sv
rtl/dwpw_pos.sv
rtl/dwpw_seq.sv
rtl/display_window_pixel_writer.sv
rtl/dwpw_checker.sv
verif/display_window_pixel_writer_test.sv
